>>> src/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared constants, types and character helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [1:0] PHASE_NORMAL = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic       emit;
    logic [7:0] plain_byte;
    logic       bad_digit;
  } dec_res_t;

  function automatic logic is_unreserved(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A],
                     8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27,
                     8'h28, 8'h29};
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  // non-hex reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      v = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

>>> src/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Escape phase tracking and per-byte decode; state advances on each transfer
// out of the input register.
// ----------------------------------------------------------------------------
module upd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      text_byte,
  input  logic            is_last,
  output upd_pkg::dec_res_t res
);
  import upd_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       first_bad_r, first_bad_nxt;

  always_comb begin
    res             = '0;
    phase_nxt       = PHASE_NORMAL;
    high_nibble_nxt = high_nibble_r;
    first_bad_nxt   = first_bad_r;
    case (phase_r)
      PHASE_FIRST: begin
        high_nibble_nxt = hex_value(text_byte);
        first_bad_nxt   = !is_hex(text_byte);
        phase_nxt       = is_last ? PHASE_NORMAL : PHASE_SECOND;
      end
      PHASE_SECOND: begin
        res.emit       = 1'b1;
        res.plain_byte = {high_nibble_r, hex_value(text_byte)};
        res.bad_digit  = first_bad_r | !is_hex(text_byte);
      end
      default: begin
        if (is_unreserved(text_byte)) begin
          res.emit       = 1'b1;
          res.plain_byte = text_byte;
        end else if (text_byte == CH_PLUS) begin
          res.emit       = 1'b1;
          res.plain_byte = CH_SPACE;
        end else if (text_byte == CH_PERCENT && !is_last) begin
          phase_nxt = PHASE_FIRST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PHASE_NORMAL;
      high_nibble_r <= 4'd0;
      first_bad_r   <= 1'b0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      high_nibble_r <= high_nibble_nxt;
      first_bad_r   <= first_bad_nxt;
    end
  end

endmodule

>>> src/upd_out_reg.sv
// ----------------------------------------------------------------------------
// upd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module upd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upd_pkg::dec_res_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_plain_byte,
  output logic              out_bad_digit,
  output logic              free
);
  import upd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] plain_byte_r;
  logic       bad_digit_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plain_byte_r <= res.plain_byte;
      bad_digit_r  <= res.bad_digit;
    end
  end

  assign out_valid      = valid_r;
  assign out_plain_byte = plain_byte_r;
  assign out_bad_digit  = bad_digit_r;

endmodule

>>> src/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Path: input register, then decode, then the result register (out_valid).
// Throughput: one byte per cycle while not stalled; the input register and
// the result register each hold one item, and decode sits between them. A
// stalled result holds the input only when the byte in the input register
// also decodes to a result.
// Reset: synchronous, active low; clears both valid flags and the escape state.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_plain_byte,
  output logic       out_bad_digit
);
  import upd_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       in_xfer;
  logic       s1_fire;
  logic       free;
  dec_res_t   res;

  assign s1_fire  = s1_valid_r && (!res.emit || free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_is_last;
    end
  end

  upd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .text_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .res       (res)
  );

  upd_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_fire && res.emit),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_plain_byte (out_plain_byte),
    .out_bad_digit  (out_bad_digit),
    .free           (free)
  );

endmodule

>>> test/url_percent_decoder_tb.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Streams directed and random percent-encoded strings into the decoder with
// random idle bursts on both sides, a long output hold-off and a full drain.
// A scoreboard tracks the escape state, predicts each decoded byte and checks
// every output transfer in order.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES = 300;

  class decoded_byte_book;
    typedef struct {
      logic [7:0] plain;
      logic       bad;
    } plain_t;

    plain_t     exp_plain[$];
    logic [1:0] phase;
    logic [3:0] hi_nib;
    logic       hi_bad;
    int         mismatches;

    function new();
      phase      = PHASE_NORMAL;
      hi_nib     = 4'd0;
      hi_bad     = 1'b0;
      mismatches = 0;
    endfunction

    static function logic [3:0] hex_digit(input logic [7:0] b, output logic bad);
      bad = 1'b0;
      if (b >= "0" && b <= "9") return 4'(b - "0");
      if (b >= "a" && b <= "f") return 4'(b - "a" + 8'd10);
      if (b >= "A" && b <= "F") return 4'(b - "A" + 8'd10);
      bad = 1'b1;
      return 4'd0;
    endfunction

    static function bit url_safe(input logic [7:0] b);
      if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
        return 1'b1;
      case (b)
        "-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // returns 1 when the byte produced a result or moved the escape state
    function bit note_text_byte(input logic [7:0] b, input logic last);
      logic [3:0] nib;
      logic       bad;
      logic [1:0] was;
      bit         made;
      plain_t     p;
      was  = phase;
      made = 1'b0;
      case (phase)
        PHASE_FIRST: begin
          hi_nib = hex_digit(b, bad);
          hi_bad = bad;
          phase  = last ? PHASE_NORMAL : PHASE_SECOND;
        end
        PHASE_SECOND: begin
          nib     = hex_digit(b, bad);
          p.plain = {hi_nib, nib};
          p.bad   = hi_bad | bad;
          made    = 1'b1;
          phase   = PHASE_NORMAL;
        end
        default: begin
          phase = PHASE_NORMAL;
          if (url_safe(b)) begin
            p.plain = b;
            p.bad   = 1'b0;
            made    = 1'b1;
          end else if (b == CH_PLUS) begin
            p.plain = CH_SPACE;
            p.bad   = 1'b0;
            made    = 1'b1;
          end else if (b == CH_PERCENT && !last) begin
            phase = PHASE_FIRST;
          end
        end
      endcase
      if (made) exp_plain.push_back(p);
      return made || (phase != was);
    endfunction

    function void check_plain_byte(input logic [7:0] b, input logic bad);
      plain_t p;
      if (exp_plain.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual plain_byte=%h bad_digit=%b",
                 $time, b, bad);
        mismatches++;
        return;
      end
      p = exp_plain.pop_front();
      if (b !== p.plain) begin
        $display("%0t: plain_byte mismatch, expected %h, actual %h", $time, p.plain, b);
        mismatches++;
      end
      if (bad !== p.bad) begin
        $display("%0t: bad_digit mismatch, expected %b, actual %b", $time, p.bad, bad);
        mismatches++;
      end
    endfunction

    function int pending();
      return exp_plain.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'd0;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_plain_byte;
  logic       out_bad_digit;

  logic       calm = 1'b0;
  logic       hold_req = 1'b0;
  int         cycle_count = 0;
  int         counted = 0;
  logic [7:0] text_q[$];
  string      safe_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.!~*'()";
  string      hex_chars = "0123456789abcdefABCDEF";

  decoded_byte_book book = new();

  url_percent_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_plain_byte (out_plain_byte),
    .out_bad_digit  (out_bad_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check transfers, random stall bursts, one long hold-off
  initial begin
    int  burst;
    int  hold_left;
    bit  hold_done;
    burst     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0)
        book.check_plain_byte(out_plain_byte, out_bad_digit);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_text(input logic [7:0] b, input logic last);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (book.note_text_byte(b, last)) counted++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic flush_text();
    for (int i = 0; i < text_q.size(); i++) send_text(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    flush_text();
  endtask

  // mostly a real hex digit, sometimes a non-hex byte
  function automatic logic [7:0] pick_digit();
    logic [7:0] b;
    logic       bad;
    if ($urandom_range(0, 7) != 0) return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
    do begin
      b = 8'($urandom_range(0, 255));
      void'(decoded_byte_book::hex_digit(b, bad));
    end while (!bad);
    return b;
  endfunction

  task automatic build_string();
    int k;
    repeat ($urandom_range(1, 8)) begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        text_q.push_back(safe_chars[$urandom_range(0, safe_chars.len() - 1)]);
      end else if (k == 5) begin
        text_q.push_back(CH_PLUS);
      end else if (k < 9) begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(pick_digit());
        text_q.push_back(pick_digit());
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int kind;
    bit hold_sent;
    bit drained;
    hold_sent = 1'b0;
    drained   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass-through, plus, dropped bytes, escapes, truncated escapes
    send_str("Az9~'");
    send_str("+");
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text("/", 1'b1);
    send_str("%Ff%g1%aZ");
    send_str("%");
    send_str("%7");
    send_str("%41");

    while (counted < RANDOM_ITEMS) begin
      if (!hold_sent && counted > 300) begin
        hold_req  <= 1'b1;
        hold_sent = 1'b1;
      end
      if (!drained && counted > 600) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
        drained = 1'b1;
      end
      if (counted > RANDOM_ITEMS - 200) calm <= 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_string();
        if (kind >= 7) begin
          text_q.push_back(CH_PERCENT);
          if (kind == 8) text_q.push_back(pick_digit());
        end
      end
      flush_text();
    end

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
